>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define RSP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/rsp_pkg.sv
package rsp_pkg;

  // Widths
  localparam int RSP_TIME_W = 32;
  localparam int STEP_W     = 8;
  localparam int POS_W      = 7;
  localparam int MTIME_W    = 15;
  localparam int DIV_W      = 12;   // step time times ten fits here
  localparam int ALU_W      = 16;
  localparam int OP_W       = 3;
  localparam int ORD_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [POS_W-1:0] POS_MAX = 7'd100;

  // Motion codes
  localparam logic [ORD_W-1:0] MOTION_UP   = 2'd0;
  localparam logic [ORD_W-1:0] MOTION_DOWN = 2'd1;
  localparam logic [ORD_W-1:0] MOTION_STOP = 2'd2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ORDER  = 3'd0;
  localparam logic [OP_W-1:0] OP_BUTTON = 3'd1;
  localparam logic [OP_W-1:0] OP_TARGET = 3'd2;
  localparam logic [OP_W-1:0] OP_APPLY  = 3'd3;
  localparam logic [OP_W-1:0] OP_TRAVEL = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UP_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_LVL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LVL  = 3'd3;

  // Shared unit control
  typedef enum logic {
    UNIT_MUL,
    UNIT_DIV
  } unit_mode_t;

  typedef struct packed {
    logic       start;
    unit_mode_t mode;
  } rsp_unit_req_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } rsp_unit_rsp_t;

endpackage

>>> rtl/core/rsp_channels.sv
interface rsp_in_if
  import rsp_pkg::*;
#(
  parameter int TIME_WIDTH = RSP_TIME_W
);
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       operation;
  logic [ORD_W-1:0]      order;
  logic [POS_W-1:0]      target_position;
  logic                  travel_down;
  logic [TIME_WIDTH-1:0] measured_time;

  modport source (output valid, operation, order, target_position, travel_down,
                  measured_time, input ready);
  modport sink   (input valid, operation, order, target_position, travel_down,
                  measured_time, output ready);
endinterface

interface rsp_out_if
  import rsp_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [MTIME_W-1:0] movement_time;
  logic               up_relay;
  logic               down_relay;
  logic [ORD_W-1:0]   motion_state;
  logic [POS_W-1:0]   position;

  modport source (output valid, movement_time, up_relay, down_relay, motion_state,
                  position, input ready);
  modport sink   (input valid, movement_time, up_relay, down_relay, motion_state,
                  position, output ready);
endinterface

interface rsp_cfg_if
  import rsp_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/rsp_unit.sv
module rsp_unit
  import rsp_pkg::*;
#(
  parameter int TIME_WIDTH = RSP_TIME_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rsp_unit_req_t         req_i,
  input  logic [STEP_W-1:0]     step_i,
  input  logic [POS_W-1:0]      mult_i,
  input  logic [TIME_WIDTH-1:0] dividend_i,
  output rsp_unit_rsp_t         rsp_o,
  output logic [MTIME_W-1:0]    product_o,
  output logic [TIME_WIDTH-1:0] quotient_o
);

  localparam int CNT_W = $clog2(TIME_WIDTH);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(TIME_WIDTH - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(POS_W - 1);

  typedef enum logic [1:0] {
    U_IDLE,
    U_SCALE,
    U_DIV,
    U_MUL
  } ustate_t;

  ustate_t               state_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIV_W-1:0]      div_r;
  logic [DIV_W-1:0]      rem_r;
  logic [TIME_WIDTH-1:0] quo_r;
  logic [MTIME_W-1:0]    acc_r;
  logic [MTIME_W-1:0]    mcand_r;
  logic [POS_W-1:0]      mplier_r;
  logic                  done_r;

  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  logic             alu_sub;
  logic [ALU_W:0]   alu_sum;
  logic             alu_carry;
  logic [DIV_W:0]   rem_sh;

  // Bring the next dividend bit into the partial remainder
  assign rem_sh = {rem_r, quo_r[TIME_WIDTH-1]};

  // Select operands for the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      U_SCALE: begin
        alu_a = ALU_W'({div_r, 3'b000});
        alu_b = ALU_W'({div_r, 1'b0});
      end
      U_DIV: begin
        alu_a   = ALU_W'(rem_sh);
        alu_b   = ALU_W'(div_r);
        alu_sub = 1'b1;
      end
      U_MUL: begin
        alu_a = ALU_W'(acc_r);
        alu_b = mplier_r[0] ? ALU_W'(mcand_r) : '0;
      end
      default: begin
      end
    endcase
  end

  // Shared add/subtract; carry out means no borrow on subtract
  assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + (ALU_W + 1)'(alu_sub);
  assign alu_carry = alu_sum[ALU_W];

  // Sequence scale, divide and multiply steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        U_IDLE: begin
          if (req_i.start) begin
            cnt_r <= '0;
            if (req_i.mode == UNIT_DIV) begin
              div_r   <= DIV_W'(step_i);
              rem_r   <= '0;
              quo_r   <= dividend_i;
              state_r <= U_SCALE;
            end else begin
              acc_r    <= '0;
              mcand_r  <= MTIME_W'(step_i);
              mplier_r <= mult_i;
              state_r  <= U_MUL;
            end
          end
        end
        U_SCALE: begin
          div_r   <= alu_sum[DIV_W-1:0];
          state_r <= U_DIV;
        end
        U_DIV: begin
          rem_r <= alu_carry ? alu_sum[DIV_W-1:0] : rem_sh[DIV_W-1:0];
          quo_r <= {quo_r[TIME_WIDTH-2:0], alu_carry};
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == DIV_LAST) begin
            done_r  <= 1'b1;
            state_r <= U_IDLE;
          end
        end
        U_MUL: begin
          acc_r    <= alu_sum[MTIME_W-1:0];
          mcand_r  <= {mcand_r[MTIME_W-2:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[POS_W-1:1]};
          cnt_r    <= cnt_r + CNT_W'(1);
          if (cnt_r == MUL_LAST) begin
            done_r  <= 1'b1;
            state_r <= U_IDLE;
          end
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign rsp_o.done   = done_r;
  assign rsp_o.rem_nz = |rem_r;
  assign product_o    = acc_r;
  assign quotient_o   = quo_r;

endmodule

>>> rtl/core/roller_shutter_position_control.sv
// Orders, buttons, apply and unused codes go straight to ST_FIN; the result is registered
// there once the output is free, and the next item is taken only back in ST_IDLE.
// Target position: the shared unit first runs 7 shift-add steps (ST_WORK).
// Travel report: the shared unit first scales the step time by ten, then the serial
// divider yields one quotient bit a cycle; a zero step time skips the unit.
// Reset (synchronous, rst_n low): stopped, position 0, step times 0, levels 1/0.
module roller_shutter_position_control
  import rsp_pkg::*;
#(
  parameter int TIME_WIDTH = RSP_TIME_W
) (
  input  logic    clk,
  input  logic    rst_n,
  rsp_in_if.sink  in_ch,
  rsp_out_if.source out_ch,
  rsp_cfg_if.sink cfg_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_FIN
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [STEP_W-1:0] up_step_r;
  logic [STEP_W-1:0] down_step_r;
  logic              act_lvl_r;
  logic              idle_lvl_r;

  // Block state
  logic [ORD_W-1:0] cur_r;
  logic [ORD_W-1:0] pend_r;
  logic [POS_W-1:0] pos_r;

  // Latched item
  logic [OP_W-1:0]  op_r;
  logic [ORD_W-1:0] ord_r;
  logic             trav_down_r;
  logic             aim_down_r;

  // Output register
  logic               out_valid_r;
  logic [MTIME_W-1:0] out_time_r;
  logic               out_up_r;
  logic               out_dn_r;
  logic [ORD_W-1:0]   out_motion_r;
  logic [POS_W-1:0]   out_pos_r;

  logic               in_acc;
  logic               aim_down;
  logic [POS_W-1:0]   span;
  logic [STEP_W-1:0]  trav_step_in;
  rsp_unit_req_t      unit_req;
  rsp_unit_rsp_t      unit_rsp;
  logic [STEP_W-1:0]  unit_step;
  logic [MTIME_W-1:0] product;
  logic [TIME_WIDTH-1:0] quotient;
  logic               out_free;

  logic [MTIME_W-1:0] time_c;
  logic [ORD_W-1:0]   cur_c;
  logic [ORD_W-1:0]   pend_c;
  logic [POS_W-1:0]   pos_c;
  logic               q_big;
  logic [POS_W:0]     sum_dn;
  logic [POS_W:0]     sub_up;
  logic [STEP_W-1:0]  trav_step;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  // Pick direction, distance and step time for the shared unit
  assign aim_down     = in_ch.target_position > pos_r;
  assign span         = aim_down ? (in_ch.target_position - pos_r)
                                 : (pos_r - in_ch.target_position);
  assign trav_step_in = in_ch.travel_down ? down_step_r : up_step_r;

  always_comb begin
    unit_req.start = 1'b0;
    unit_req.mode  = UNIT_MUL;
    unit_step      = aim_down ? down_step_r : up_step_r;
    if (in_acc && in_ch.operation == OP_TARGET) begin
      unit_req.start = 1'b1;
    end else if (in_acc && in_ch.operation == OP_TRAVEL && trav_step_in != '0) begin
      unit_req.start = 1'b1;
      unit_req.mode  = UNIT_DIV;
      unit_step      = trav_step_in;
    end
  end

  rsp_unit #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_unit (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_i      (unit_req),
    .step_i     (unit_step),
    .mult_i     (span),
    .dividend_i (in_ch.measured_time),
    .rsp_o      (unit_rsp),
    .product_o  (product),
    .quotient_o (quotient)
  );

  // Work out the new state and the result of the held item
  assign trav_step = trav_down_r ? down_step_r : up_step_r;
  assign q_big     = |quotient[TIME_WIDTH-1:POS_W];
  assign sum_dn    = {1'b0, pos_r} + {1'b0, quotient[POS_W-1:0]};
  assign sub_up    = {1'b0, quotient[POS_W-1:0]} + (POS_W + 1)'(unit_rsp.rem_nz);

  always_comb begin
    time_c = '0;
    cur_c  = cur_r;
    pend_c = pend_r;
    pos_c  = pos_r;
    unique case (op_r) inside
      OP_ORDER, OP_BUTTON: begin
        pend_c = MOTION_STOP;
        if (cur_r == MOTION_STOP) begin
          if (ord_r == MOTION_UP) begin
            pend_c = MOTION_UP;
            time_c = MTIME_W'(up_step_r);
          end else if (ord_r == MOTION_DOWN) begin
            pend_c = MOTION_DOWN;
            time_c = MTIME_W'(down_step_r);
          end
        end
      end
      OP_TARGET: begin
        pend_c = aim_down_r ? MOTION_DOWN : MOTION_UP;
        time_c = product;
      end
      OP_APPLY: cur_c = pend_r;
      OP_TRAVEL: begin
        if (trav_step == '0) begin
          // zero step time runs straight to the end stop
          pos_c = trav_down_r ? POS_MAX : '0;
        end else if (trav_down_r) begin
          pos_c = (q_big || sum_dn > {1'b0, POS_MAX}) ? POS_MAX : sum_dn[POS_W-1:0];
        end else begin
          pos_c = (q_big || sub_up >= {1'b0, pos_r}) ? '0
                                                      : pos_r - sub_up[POS_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Sequence items and hold the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= MOTION_STOP;
      pend_r      <= MOTION_STOP;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the beat once taken, unless a new one loads in its place
      if (out_valid_r && out_ch.ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            op_r        <= in_ch.operation;
            ord_r       <= in_ch.order;
            trav_down_r <= in_ch.travel_down;
            aim_down_r  <= aim_down;
            state_r     <= unit_req.start ? ST_WORK : ST_FIN;
          end
        end
        ST_WORK: begin
          if (unit_rsp.done) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            cur_r        <= cur_c;
            pend_r       <= pend_c;
            pos_r        <= pos_c;
            out_valid_r  <= 1'b1;
            out_time_r   <= time_c;
            out_up_r     <= (cur_c == MOTION_UP) ? act_lvl_r : idle_lvl_r;
            out_dn_r     <= (cur_c == MOTION_DOWN) ? act_lvl_r : idle_lvl_r;
            out_motion_r <= cur_c;
            out_pos_r    <= pos_c;
            state_r      <= ST_IDLE;
          end else begin
            out_valid_r  <= 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_step_r   <= '0;
      down_step_r <= '0;
      act_lvl_r   <= 1'b1;
      idle_lvl_r  <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_UP_STEP:   up_step_r   <= cfg_ch.data;
        CFG_DOWN_STEP: down_step_r <= cfg_ch.data;
        CFG_ACT_LVL:   act_lvl_r   <= cfg_ch.data[0];
        CFG_IDLE_LVL:  idle_lvl_r  <= cfg_ch.data[0];
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.movement_time = out_time_r;
  assign out_ch.up_relay      = out_up_r;
  assign out_ch.down_relay    = out_dn_r;
  assign out_ch.motion_state  = out_motion_r;
  assign out_ch.position      = out_pos_r;

endmodule

>>> rtl/core/rsp_checker.sv
`include "assert_macros.svh"

module rsp_checker
  import rsp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [MTIME_W-1:0] out_time,
  input logic               out_up,
  input logic               out_dn,
  input logic [ORD_W-1:0]   out_motion,
  input logic [POS_W-1:0]   out_pos
);

  // A stalled result beat holds
  `RSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_time, out_up, out_dn, out_motion, out_pos}), "result beat changed while stalled")

  // One item at a time: busy right after an accept
  `RSP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "input taken while an item is in work")

  // Position estimate stays within travel
  `RSP_ASSERT(a_pos_range, clk, rst_n, !out_valid || out_pos <= POS_MAX, "position above end stop")

  // A stopped shutter drives both relays to the same idle level
  `RSP_ASSERT(a_stop_relays, clk, rst_n, !(out_valid && out_motion == MOTION_STOP) || out_up == out_dn, "relays differ while stopped")

endmodule

bind roller_shutter_position_control rsp_checker u_rsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_time   (out_ch.movement_time),
  .out_up     (out_ch.up_relay),
  .out_dn     (out_ch.down_relay),
  .out_motion (out_ch.motion_state),
  .out_pos    (out_ch.position)
);
